FILE: hdl/assert_macros.svh
// assertion helpers, clock and reset names fixed to the house ports
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define BIS_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define BIS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/bis_pkg.sv
package bis_pkg;

   localparam int CSR_DATA_BITS = 16;
   localparam int SIDE_BITS     = 7;
   localparam int COORD_BITS    = 16;
   localparam int LOAD_BITS     = 16;
   localparam int SAMPLE_BITS   = 17;

   localparam logic CMD_LOAD   = 1'b0;
   localparam logic CMD_SAMPLE = 1'b1;

   localparam logic [1:0] CSR_HEIGHT = 2'd0;
   localparam logic [1:0] CSR_WIDTH  = 2'd1;

   localparam logic [1:0] NB_LAST = 2'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic       capture;
      logic       issue;
      logic [1:0] nb;
   } blend_ctrl_type;

endpackage

FILE: hdl/bis_ram.sv
module bis_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_ff[addr] <= wdata;
         end else begin
            rdata_ff <= mem_ff[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: hdl/bis_blend.sv
module bis_blend #(
   parameter int MAX_SIDE   = 64,
   parameter int PIXEL_BITS = 16
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  bis_pkg::blend_ctrl_type                    ctrl,
   input  logic signed [bis_pkg::COORD_BITS-1:0]      coord_x,
   input  logic signed [bis_pkg::COORD_BITS-1:0]      coord_y,
   input  logic [bis_pkg::SIDE_BITS-1:0]              side_h,
   input  logic [bis_pkg::SIDE_BITS-1:0]              side_w,
   output logic                                       rd_en,
   output logic [$clog2(MAX_SIDE*MAX_SIDE)-1:0]       rd_addr,
   input  logic [PIXEL_BITS-1:0]                      rd_data,
   output logic signed [bis_pkg::SAMPLE_BITS-1:0]     result
);
   import bis_pkg::*;

   localparam int AW   = $clog2(MAX_SIDE * MAX_SIDE);
   localparam int PW   = PIXEL_BITS + 18;
   localparam int ACCW = (PIXEL_BITS + 19 > 34) ? PIXEL_BITS + 19 : 34;
   localparam int RESW = ACCW - 16;

   logic signed [16:0]   px_sum, py_sum;
   logic signed [24:0]   prod_x, prod_y;
   logic signed [22:0]   x_ff, x_in, y_ff, y_in;
   logic [8:0]           m, n;
   logic [13:0]          fx, fy;
   logic [9:0]           row, col;
   logic                 in_image;
   logic [14:0]          wx, wy;
   logic [29:0]          wprod;
   logic [16:0]          wt_ff, wt_in;
   logic                 in_image_ff, take_ff;
   logic signed [PIXEL_BITS-1:0] pix;
   logic signed [PW-1:0]   pprod;
   logic signed [ACCW-1:0] acc_ff, acc_in;
   logic signed [RESW-1:0] res;

   // map normalised coordinate to image space, floor halving by arithmetic shift
   always_comb begin
      px_sum = $signed({coord_x[COORD_BITS-1], coord_x}) + 17'sd16384;
      py_sum = $signed({coord_y[COORD_BITS-1], coord_y}) + 17'sd16384;
      prod_x = 25'(px_sum) * 25'($signed({1'b0, side_h}));
      prod_y = 25'(py_sum) * 25'($signed({1'b0, side_w}));
      x_in   = $signed(prod_x[23:1]);
      y_in   = $signed(prod_y[23:1]);
   end

   always_comb begin
      m   = x_ff[22:14];
      n   = y_ff[22:14];
      fx  = x_ff[13:0];
      fy  = y_ff[13:0];
      row = {m[8], m} + {9'd0, ctrl.nb[1]};
      col = {n[8], n} + {9'd0, ctrl.nb[0]};
      in_image = !row[9] && (row[8:0] < {2'b00, side_h})
              && !col[9] && (col[8:0] < {2'b00, side_w});
      rd_addr = AW'(row[8:0]) * AW'(MAX_SIDE) + AW'(col[8:0]);
      rd_en   = ctrl.issue && in_image;
      wx = ctrl.nb[1] ? {1'b0, fx} : 15'd16384 - {1'b0, fx};
      wy = ctrl.nb[0] ? {1'b0, fy} : 15'd16384 - {1'b0, fy};
      wprod = 30'(wx) * 30'(wy);
      // truncate Q1.28 to Q1.16, one whole is kept in the top bit
      wt_in = wprod[28:12];
   end

   always_comb begin
      pix    = rd_data;
      pprod  = PW'($signed({1'b0, wt_ff})) * PW'(pix);
      acc_in = acc_ff;
      if (ctrl.capture) begin
         acc_in = '0;
      end else if (take_ff && in_image_ff) begin
         acc_in = acc_ff + ACCW'(pprod);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         take_ff <= 1'b0;
      end else begin
         take_ff <= ctrl.issue;
      end
      if (ctrl.capture) begin
         x_ff <= x_in;
         y_ff <= y_in;
      end
      if (ctrl.issue) begin
         wt_ff       <= wt_in;
         in_image_ff <= in_image;
      end
      acc_ff <= acc_in;
   end

   always_comb begin
      res = $signed(acc_ff[ACCW-1:16]);
      if (res > RESW'(65535)) begin
         result = 17'sd65535;
      end else if (res < RESW'(-65536)) begin
         result = -17'sd65536;
      end else begin
         result = res[SAMPLE_BITS-1:0];
      end
   end

endmodule

FILE: hdl/bilinear_image_sampler_core.sv
// load item: pixel written at the accepting edge
// sample item: read, drain, finish until output free; next item only taken in idle
// the four neighbour reads share the single image memory port, one per cycle
// synchronous active-high reset clears control and sets both sides to 64 (capped)
// image memory holds no reset value; pixels must be loaded before they are sampled
module bilinear_image_sampler_core #(
   parameter int MAX_SIDE   = 64,
   parameter int PIXEL_BITS = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic                                   req_command,
   input  logic [5:0]                             req_load_row,
   input  logic [5:0]                             req_load_col,
   input  logic signed [bis_pkg::LOAD_BITS-1:0]   req_pixel_value,
   input  logic signed [bis_pkg::COORD_BITS-1:0]  req_coord_x,
   input  logic signed [bis_pkg::COORD_BITS-1:0]  req_coord_y,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [bis_pkg::SAMPLE_BITS-1:0] rsp_sample_value,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [1:0]                             csr_index,
   input  logic [bis_pkg::CSR_DATA_BITS-1:0]      csr_wdata
);
   import bis_pkg::*;
`include "assert_macros.svh"

   localparam int AW       = $clog2(MAX_SIDE * MAX_SIDE);
   localparam int SIDE_CAP = (MAX_SIDE > 127) ? 127 : MAX_SIDE;
   localparam int SIDE_RST = (MAX_SIDE > 64) ? 64 : MAX_SIDE;

   state_type state_ff, state_in;
   logic [1:0] nb_ff, nb_in;
   logic [SIDE_BITS-1:0] side_h_ff, side_w_ff, csr_side;
   logic rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] rsp_value_ff, blend_result;
   logic req_fire, load_fire, sample_fire, load_ok, rsp_load;
   blend_ctrl_type ctrl;
   logic blend_rd_en, ram_en, ram_we;
   logic [AW-1:0] blend_addr, load_addr, ram_addr;
   logic [PIXEL_BITS-1:0] ram_rdata, ram_wdata;

   assign req_fire    = req_valid && req_ready;
   assign load_fire   = req_fire && (req_command == CMD_LOAD);
   assign sample_fire = req_fire && (req_command == CMD_SAMPLE);
   assign csr_ready   = 1'b1;

   // zero acts as one, anything beyond the store acts as the store side
   always_comb begin
      csr_side = csr_wdata[SIDE_BITS-1:0];
      if (csr_side == '0) begin
         csr_side = SIDE_BITS'(1);
      end else if (32'(csr_side) > SIDE_CAP) begin
         csr_side = SIDE_BITS'(SIDE_CAP);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_h_ff <= SIDE_BITS'(SIDE_RST);
         side_w_ff <= SIDE_BITS'(SIDE_RST);
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CSR_HEIGHT) begin
            side_h_ff <= csr_side;
         end else if (csr_index == CSR_WIDTH) begin
            side_w_ff <= csr_side;
         end
      end
   end

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      nb_in    = nb_ff;
      case (state_ff)
         ST_IDLE: begin
            if (sample_fire) begin
               state_in = ST_READ;
               nb_in    = '0;
            end
         end
         ST_READ: begin
            nb_in = nb_ff + 2'd1;
            if (nb_ff == NB_LAST) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_ready    = 1'b0;
      ctrl.capture = 1'b0;
      ctrl.issue   = 1'b0;
      ctrl.nb      = nb_ff;
      rsp_load     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready    = 1'b1;
            ctrl.capture = sample_fire;
         end
         ST_READ: begin
            ctrl.issue = 1'b1;
         end
         ST_DRAIN: begin
         end
         ST_FINISH: begin
            rsp_load = !rsp_valid_ff || rsp_ready;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         nb_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         nb_ff        <= nb_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (rsp_load) begin
         rsp_value_ff <= blend_result;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sample_value = rsp_value_ff;

   // loads go straight in while idle, reads only happen during the read phase
   always_comb begin
      load_ok   = (32'(req_load_row) < MAX_SIDE) && (32'(req_load_col) < MAX_SIDE);
      load_addr = AW'(req_load_row) * AW'(MAX_SIDE) + AW'(req_load_col);
      ram_wdata = PIXEL_BITS'(req_pixel_value);
      ram_we    = load_fire && load_ok;
      ram_en    = ram_we || blend_rd_en;
      ram_addr  = ram_we ? load_addr : blend_addr;
   end

   bis_ram #(
      .WIDTH(PIXEL_BITS),
      .DEPTH(MAX_SIDE * MAX_SIDE)
   ) u_image (
      .clock(clock),
      .en   (ram_en),
      .we   (ram_we),
      .addr (ram_addr),
      .wdata(ram_wdata),
      .rdata(ram_rdata)
   );

   bis_blend #(
      .MAX_SIDE  (MAX_SIDE),
      .PIXEL_BITS(PIXEL_BITS)
   ) u_blend (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ctrl),
      .coord_x(req_coord_x),
      .coord_y(req_coord_y),
      .side_h (side_h_ff),
      .side_w (side_w_ff),
      .rd_en  (blend_rd_en),
      .rd_addr(blend_addr),
      .rd_data(ram_rdata),
      .result (blend_result)
   );

   `BIS_ASSERT_NOW(a_no_rw_clash, blend_rd_en, !ram_we, "image read and write in one cycle")
   `BIS_ASSERT_NEXT(a_sample_starts, sample_fire, state_ff == ST_READ && nb_ff == 2'd0, "sample item did not start reads")
   `BIS_ASSERT_NEXT(a_last_read, state_ff == ST_READ && nb_ff == NB_LAST, state_ff == ST_DRAIN, "read phase overran")
   `BIS_ASSERT_NEXT(a_result_shown, rsp_load, rsp_valid, "finished item not presented")

endmodule

FILE: verif/bilinear_sample_checker.sv
module bilinear_sample_checker (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   input  logic                                   req_ready,
   input  logic                                   req_command,
   input  logic [5:0]                             req_load_row,
   input  logic [5:0]                             req_load_col,
   input  logic signed [bis_pkg::LOAD_BITS-1:0]   req_pixel_value,
   input  logic signed [bis_pkg::COORD_BITS-1:0]  req_coord_x,
   input  logic signed [bis_pkg::COORD_BITS-1:0]  req_coord_y,
   input  logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   input  logic signed [bis_pkg::SAMPLE_BITS-1:0] rsp_sample_value,
   input  logic                                   csr_valid,
   input  logic                                   csr_ready,
   input  logic [1:0]                             csr_index,
   input  logic [bis_pkg::CSR_DATA_BITS-1:0]      csr_wdata,
   output int                                     fail_count,
   output int                                     outstanding,
   output int                                     samples_checked
);
   timeunit 1ns;
   timeprecision 1ps;
   import bis_pkg::*;

   localparam int STORE_SIDE = 64;

   logic [LOAD_BITS-1:0]          pixel_mem [0:STORE_SIDE*STORE_SIDE-1];
   logic [SIDE_BITS-1:0]          height_reg;
   logic [SIDE_BITS-1:0]          width_reg;
   logic signed [SAMPLE_BITS-1:0] expected_samples [$];
   logic signed [SAMPLE_BITS-1:0] expected_value;

   // zero acts as one, anything past the store acts as the full side
   function automatic longint side_in_use(logic [SIDE_BITS-1:0] raw);
      if (raw == 0) return 1;
      if (raw > STORE_SIDE) return STORE_SIDE;
      return longint'(raw);
   endfunction

   // neighbours outside the image in use contribute nothing
   function automatic longint neighbour_pixel(longint r, longint c, longint h, longint w);
      logic signed [LOAD_BITS-1:0] p;
      if (r < 0 || r >= h || c < 0 || c >= w) return 0;
      p = pixel_mem[r*STORE_SIDE + c];
      return longint'(p);
   endfunction

   function automatic logic signed [SAMPLE_BITS-1:0] blend_sample(
      logic signed [COORD_BITS-1:0] cx, logic signed [COORD_BITS-1:0] cy);
      longint h, w, x, y, m, n, fx, fy, acc, wt, res;
      longint wx [2];
      longint wy [2];
      h = side_in_use(height_reg);
      w = side_in_use(width_reg);
      // q.14 image position, halving rounds toward minus infinity
      x = ((longint'(cx) + 16384) * h) >>> 1;
      y = ((longint'(cy) + 16384) * w) >>> 1;
      m = x >>> 14;
      n = y >>> 14;
      fx = x - m * 16384;
      fy = y - n * 16384;
      wx[0] = 16384 - fx;
      wx[1] = fx;
      wy[0] = 16384 - fy;
      wy[1] = fy;
      acc = 0;
      for (int i = 0; i < 2; i++) begin
         for (int j = 0; j < 2; j++) begin
            wt = (wx[i] * wy[j]) >>> 12;
            acc += wt * neighbour_pixel(m + i, n + j, h, w);
         end
      end
      res = acc >>> 16;
      if (res > 65535) res = 65535;
      if (res < -65536) res = -65536;
      return SAMPLE_BITS'(res);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         expected_samples.delete();
         height_reg      <= 7'd64;
         width_reg       <= 7'd64;
         outstanding     <= 0;
         fail_count      <= 0;
         samples_checked <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_HEIGHT: height_reg <= csr_wdata[SIDE_BITS-1:0];
               CSR_WIDTH:  width_reg  <= csr_wdata[SIDE_BITS-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_samples.size() == 0) begin
               $error("sample_value: no item expected, got %0d", rsp_sample_value);
               fail_count <= fail_count + 1;
            end else begin
               expected_value = expected_samples.pop_front();
               if (rsp_sample_value !== expected_value) begin
                  $error("sample_value: expected %0d, got %0d",
                         expected_value, rsp_sample_value);
                  fail_count <= fail_count + 1;
               end
               samples_checked <= samples_checked + 1;
            end
         end
         if (req_valid && req_ready) begin
            if (req_command == CMD_LOAD)
               pixel_mem[{req_load_row, req_load_col}] <= req_pixel_value;
            else
               expected_samples.push_back(blend_sample(req_coord_x, req_coord_y));
         end
         outstanding <= expected_samples.size();
      end
   end

endmodule

FILE: verif/bilinear_image_sampler_core_tb.sv
module bilinear_image_sampler_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import bis_pkg::*;

   // indexes with no register behind them, written to show they are ignored
   localparam logic [1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [1:0] CSR_SPARE_HI = 2'd3;
   localparam int RANDOM_ITEMS = 1400;
   localparam int HOLD_CYCLES  = 400;

   logic                         clock;
   logic                         reset;
   logic                         req_valid;
   logic                         req_ready;
   logic                         req_command;
   logic [5:0]                   req_load_row;
   logic [5:0]                   req_load_col;
   logic signed [LOAD_BITS-1:0]  req_pixel_value;
   logic signed [COORD_BITS-1:0] req_coord_x;
   logic signed [COORD_BITS-1:0] req_coord_y;
   logic                         rsp_valid;
   logic                         rsp_ready;
   logic signed [SAMPLE_BITS-1:0] rsp_sample_value;
   logic                         csr_valid;
   logic                         csr_ready;
   logic [1:0]                   csr_index;
   logic [CSR_DATA_BITS-1:0]     csr_wdata;

   int fail_count;
   int outstanding;
   int samples_checked;

   bit written [0:4095];
   int height_now;
   int width_now;
   int burst_left;
   int items_sent;
   int loads_sent;
   int settings_used;
   bit hold_armed;
   bit hold_done;

   bilinear_image_sampler_core dut (.*);

   bilinear_sample_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("[bilinear_image_sampler_core] ERROR");
      $finish;
   end

   function automatic int side_of(logic [SIDE_BITS-1:0] raw);
      if (raw == 0) return 1;
      if (raw > 64) return 64;
      return int'(raw);
   endfunction

   function automatic logic [LOAD_BITS-1:0] pick_pixel();
      case ($urandom_range(0, 9))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'hffff;
         3: return 16'h0000;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic signed [COORD_BITS-1:0] pick_coord(int side);
      int k;
      case ($urandom_range(0, 9))
         0: return 16'($urandom);
         1: begin
            case ($urandom_range(0, 6))
               0: return -16'sd32768;
               1: return 16'sd32767;
               2: return -16'sd16384;
               3: return 16'sd16384;
               4: return -16'sd16385;
               5: return 16'sd16383;
               default: return 16'sd0;
            endcase
         end
         2: begin
            // at or just below a pixel centre, so one weight is at or near a full 1.0
            k = $urandom_range(0, side);
            return 16'((k * 32768) / side - 16384);
         end
         default: return 16'(int'($urandom_range(0, 34000)) - 17000);
      endcase
   endfunction

   // bursts of items with random gaps, now and then a long run with none
   task automatic pace();
      int gap;
      if (burst_left == 0) begin
         if ($urandom_range(0, 3) != 0) begin
            gap = $urandom_range(1, 8);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? 100 : $urandom_range(1, 24);
      end
      burst_left--;
   endtask

   task automatic offer(input logic cmd, input logic [5:0] row, input logic [5:0] col,
                        input logic [15:0] pix, input logic [15:0] cx, input logic [15:0] cy);
      pace();
      req_valid       <= 1'b1;
      req_command     <= cmd;
      req_load_row    <= row;
      req_load_col    <= col;
      req_pixel_value <= pix;
      req_coord_x     <= cx;
      req_coord_y     <= cy;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
      if (cmd == CMD_LOAD) begin
         written[{row, col}] = 1'b1;
         loads_sent++;
      end
   endtask

   task automatic load_pixel(input logic [5:0] row, input logic [5:0] col,
                             input logic [15:0] pix);
      offer(CMD_LOAD, row, col, pix, 16'($urandom), 16'($urandom));
   endtask

   // any neighbour inside the image that was never loaded gets a pixel first
   task automatic sample_at(input logic signed [15:0] cx, input logic signed [15:0] cy);
      longint m, n, r, c;
      m = ((longint'(cx) + 16384) * height_now) >>> 15;
      n = ((longint'(cy) + 16384) * width_now) >>> 15;
      for (int i = 0; i < 2; i++) begin
         for (int j = 0; j < 2; j++) begin
            r = m + i;
            c = n + j;
            if (r >= 0 && r < height_now && c >= 0 && c < width_now && !written[r*64 + c])
               load_pixel(6'(r), 6'(c), pick_pixel());
         end
      end
      offer(CMD_SAMPLE, 6'($urandom), 6'($urandom), 16'($urandom), cx, cy);
   endtask

   task automatic quiesce();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      // loads give no result, so let the last one settle
      repeat (12) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_HEIGHT: height_now = side_of(data[SIDE_BITS-1:0]);
         CSR_WIDTH:  width_now  = side_of(data[SIDE_BITS-1:0]);
         default: ;
      endcase
   endtask

   task automatic configure(input logic [15:0] height_data, input logic [15:0] width_data);
      quiesce();
      write_reg(CSR_HEIGHT, height_data);
      write_reg(CSR_WIDTH, width_data);
      if ($urandom_range(0, 2) == 0)
         write_reg($urandom_range(0, 1) ? CSR_SPARE_HI : CSR_SPARE_LO, 16'($urandom));
      csr_valid <= 1'b0;
      @(posedge clock);
      settings_used++;
   endtask

   task automatic random_item();
      int sel;
      logic [5:0] row, col;
      sel = $urandom_range(0, 99);
      if (sel < 30) begin
         if ($urandom_range(0, 1)) begin
            row = 6'($urandom_range(0, height_now - 1));
            col = 6'($urandom_range(0, width_now - 1));
         end else begin
            row = 6'($urandom);
            col = 6'($urandom);
         end
         load_pixel(row, col, pick_pixel());
      end else if (sel < 36) begin
         sample_at(16'($urandom), 16'($urandom));
      end else begin
         sample_at(pick_coord(height_now), pick_coord(width_now));
      end
      if ($urandom_range(0, 149) == 0)
         quiesce();
   endtask

   // receiver: changing stall patterns, plus one long hold-off
   initial begin
      int mode, span;
      rsp_ready <= 1'b0;
      hold_done = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_armed && !hold_done) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_done = 1'b1;
         end
         mode = $urandom_range(0, 3);
         span = $urandom_range(20, 120);
         repeat (span) begin
            case (mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= 1'($urandom_range(0, 1));
               2: rsp_ready <= ($urandom_range(0, 4) == 0);
               default: rsp_ready <= ($urandom_range(0, 9) != 0);
            endcase
            @(posedge clock);
         end
      end
   end

   initial begin
      int phase, count, target;
      logic [15:0] hd, wd;
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_command     <= CMD_LOAD;
      req_load_row    <= '0;
      req_load_col    <= '0;
      req_pixel_value <= '0;
      req_coord_x     <= '0;
      req_coord_y     <= '0;
      csr_valid       <= 1'b0;
      csr_index       <= CSR_HEIGHT;
      csr_wdata       <= '0;
      height_now = 64;
      width_now  = 64;
      burst_left = 0;
      items_sent = 0;
      loads_sent = 0;
      settings_used = 1;
      hold_armed = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // extreme pixels around the near corner and one at the far corner of the store
      load_pixel(6'd0, 6'd0, 16'h8000);
      load_pixel(6'd0, 6'd1, 16'h7fff);
      load_pixel(6'd1, 6'd0, 16'h7fff);
      load_pixel(6'd1, 6'd1, 16'h8000);
      load_pixel(6'd63, 6'd63, 16'h7fff);
      sample_at(-16'sd16384, -16'sd16384);
      sample_at(-16'sd16128, -16'sd16128);
      sample_at(-16'sd16256, -16'sd16000);
      sample_at(-16'sd32768, -16'sd32768);
      sample_at(16'sd32767, 16'sd32767);
      sample_at(16'sd16384, 16'sd16384);
      sample_at(-16'sd16385, -16'sd16385);
      sample_at(16'sd16383, 16'sd16383);
      configure(16'd1, 16'd1);
      sample_at(-16'sd16384, -16'sd16384);
      sample_at(16'sd0, 16'sd0);
      // zero side acts as one, oversize acts as the full store
      configure(16'h0000, 16'h0080);
      sample_at(-16'sd16384, 16'sd8191);
      configure(16'h007f, 16'hffc0);
      sample_at(16'sd16383, 16'sd16383);
      configure(16'd64, 16'd1);
      sample_at(16'sd16000, -16'sd16384);
      configure(16'd1, 16'd64);
      sample_at(-16'sd16384, 16'sd16000);

      target = items_sent + RANDOM_ITEMS;
      phase = 0;
      while (items_sent < target) begin
         case (phase)
            0, 2: begin hd = 16'd64; wd = 16'd64; end
            1: begin hd = 16'd1; wd = 16'd1; end
            default: begin
               if ($urandom_range(0, 3) == 0) begin
                  hd = 16'($urandom);
                  wd = 16'($urandom);
               end else begin
                  hd = 16'($urandom_range(1, 64));
                  wd = 16'($urandom_range(1, 64));
               end
            end
         endcase
         configure(hd, wd);
         // receiver stops for a long while and the sender keeps pushing
         if (phase == 2) hold_armed = 1'b1;
         count = $urandom_range(60, 160);
         repeat (count) begin
            if (items_sent < target) random_item();
         end
         phase++;
      end

      quiesce();
      repeat (20) @(posedge clock);
      $display("covered %0d items (%0d pixel loads), %0d samples checked", items_sent,
               loads_sent, samples_checked);
      $display("across %0d image size settings, long output hold-off included",
               settings_used);
      if (fail_count == 0) begin
         $display("[bilinear_image_sampler_core] OK");
      end else begin
         $display("[bilinear_image_sampler_core] ERROR");
      end
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/bis_pkg.sv
hdl/bis_ram.sv
hdl/bis_blend.sv
hdl/bilinear_image_sampler_core.sv
verif/bilinear_sample_checker.sv
verif/bilinear_image_sampler_core_tb.sv
